@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on every rising clock edge outside reset.
`define B64SE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define B64SE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/b64se_pkg.sv @@
// Types, constants and the alphabet lookup for the base64 stream encoder.
`timescale 1ns / 1ps
package b64se_pkg;

  // Input word: one message byte plus its end-of-message flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // Output word: one ASCII character plus its end-of-message flag.
  typedef struct packed {
    logic [6:0] out_char;
    logic       out_last;
  } out_word_t;

  localparam int unsigned JobChars = 4;
  localparam int unsigned JobIdxW  = $clog2(JobChars);

  // One classified byte: up to four ready characters for the back end.
  typedef struct packed {
    logic [JobChars-1:0][6:0] chars;
    logic [JobIdxW-1:0]       last_idx;
    logic                     fin;
  } job_t;

  // Depth of the queue between front and back end.
  localparam int unsigned JobQDepth = 2;
  localparam int unsigned JobQPtrW  = (JobQDepth > 1) ? $clog2(JobQDepth) : 1;
  localparam int unsigned JobQCntW  = $clog2(JobQDepth + 1);

  // Position of the next byte within its group of three.
  typedef enum logic [1:0] {
    PhaseFirst  = 2'd0,
    PhaseSecond = 2'd1,
    PhaseThird  = 2'd2
  } phase_e;

  localparam logic [6:0] CharPad   = 7'h3D;  // '='
  localparam logic [6:0] CharPlus  = 7'h2B;  // '+'
  localparam logic [6:0] CharSlash = 7'h2F;  // '/'
  localparam logic [6:0] CharUpA   = 7'h41;  // 'A'
  localparam logic [6:0] CharLowA  = 7'h61;  // 'a'
  localparam logic [6:0] CharZero  = 7'h30;  // '0'

  // Maps a 6-bit group to its character in the standard alphabet.
  function automatic logic [6:0] sextet_char(logic [5:0] v);
    logic [6:0] ext;
    logic [6:0] res;
    ext = {1'b0, v};
    if (v < 6'd26) begin
      res = CharUpA + ext;
    end else if (v < 6'd52) begin
      res = CharLowA + ext - 7'd26;
    end else if (v < 6'd62) begin
      res = CharZero + ext - 7'd52;
    end else if (v == 6'd62) begin
      res = CharPlus;
    end else begin
      res = CharSlash;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/base64_stream_encoder.sv @@
// Top level of the base64 stream encoder.
`timescale 1ns / 1ps
// Base64 stream encoder with the standard alphabet and '=' padding.
//
// Input channel: a queue-style port. A word (one message byte plus a flag
// marking the final byte of the message) is taken at a rising edge where
// push_i is high and full_o is low. Output channel: the oldest character is
// on out_o while empty_o is low, and it is taken at an edge where pop_i is high.
// The final character of each message carries out_last.
//
// Each accepted byte is turned at once into a job of one to four characters
// and placed in a two-entry job queue. The back end reads one character per
// cycle, while out_o is free or being taken, from the head job into an output
// register, so each byte reaches out_o through the job queue and that register.
// The output side emits one character per cycle while the receiver takes
// them; three bytes give four characters and a final byte that leaves a group
// short adds padding, so the back end, not the input, bounds a steady stream.
// The input takes a new byte every cycle while the job queue has room.
//
// Reset clears the group position, the held bits, the job queue and the
// output valid flag. When the receiver stalls, the output word holds, the job
// queue fills, and full_o rises until characters are taken again.
module base64_stream_encoder
  import b64se_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_i,
  input  logic      push_i,
  output logic      full_o,
  output out_word_t out_o,
  output logic      empty_o,
  input  logic      pop_i
);

  job_t job_wdata, job_rdata;
  logic job_push, job_full, job_pop, job_empty;

  // Front end: classify each byte by its place in the group.
  b64se_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .push_i     (push_i),
    .full_o     (full_o),
    .job_o      (job_wdata),
    .job_push_o (job_push),
    .job_full_i (job_full)
  );

  // Decouples byte acceptance from character output.
  b64se_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_wdata),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_rdata),
    .empty_o (job_empty)
  );

  // Back end: serialize characters into the output register.
  b64se_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_rdata),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .out_o       (out_o),
    .empty_o     (empty_o),
    .pop_i       (pop_i)
  );

endmodule

@@ rtl/core/b64se_front.sv @@
// Front end: accepts bytes, tracks group position and builds character jobs.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module b64se_front
  import b64se_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_word_t in_i,
  input  logic     push_i,
  output logic     full_o,
  output job_t     job_o,
  output logic     job_push_o,
  input  logic     job_full_i
);

  phase_e     phase_q, phase_d;
  logic [3:0] leftover_q, leftover_d;
  logic       accept;

  assign full_o     = job_full_i;
  assign accept     = push_i && !job_full_i;
  assign job_push_o = accept;

  always_comb begin
    logic [7:0] b;
    logic       fin;
    b          = in_i.data_byte;
    fin        = in_i.last_byte;
    job_o      = '0;
    job_o.fin  = fin;
    phase_d    = PhaseFirst;
    leftover_d = 4'd0;
    unique case (phase_q)
      PhaseSecond: begin
        job_o.chars[0] = sextet_char({leftover_q[1:0], b[7:4]});
        if (fin) begin
          job_o.chars[1] = sextet_char({b[3:0], 2'b00});
          job_o.chars[2] = CharPad;
          job_o.last_idx = JobIdxW'(2);
        end else begin
          job_o.last_idx = '0;
          leftover_d     = b[3:0];
          phase_d        = PhaseThird;
        end
      end
      PhaseThird: begin
        job_o.chars[0] = sextet_char({leftover_q, b[7:6]});
        job_o.chars[1] = sextet_char(b[5:0]);
        job_o.last_idx = JobIdxW'(1);
      end
      default: begin
        job_o.chars[0] = sextet_char(b[7:2]);
        if (fin) begin
          job_o.chars[1] = sextet_char({b[1:0], 4'b0000});
          job_o.chars[2] = CharPad;
          job_o.chars[3] = CharPad;
          job_o.last_idx = JobIdxW'(3);
        end else begin
          job_o.last_idx = '0;
          leftover_d     = {2'b00, b[1:0]};
          phase_d        = PhaseSecond;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhaseFirst;
      leftover_q <= 4'd0;
    end else if (accept) begin
      phase_q    <= phase_d;
      leftover_q <= leftover_d;
    end
  end

  `B64SE_ASSERT(a_final_restarts, clk_i, rst_ni,
                (accept && in_i.last_byte) |=> (phase_q == PhaseFirst),
                "final byte did not return the encoder to the start of a group")
  `B64SE_ASSERT(a_first_keeps_two, clk_i, rst_ni,
                (accept && !in_i.last_byte && phase_q == PhaseFirst) |=> (leftover_q[3:2] == 2'b00),
                "first byte of a group left more than two bits behind")

endmodule

@@ rtl/core/b64se_fifo.sv @@
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module b64se_fifo
  import b64se_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output job_t rdata_o,
  output logic empty_o
);

  job_t                entries_q [JobQDepth];
  logic [JobQPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [JobQCntW-1:0] cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == JobQCntW'(JobQDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = entries_q[rd_ptr_q];

  function automatic logic [JobQPtrW-1:0] ptr_inc(logic [JobQPtrW-1:0] p);
    return (p == JobQPtrW'(JobQDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `B64SE_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > JobQCntW'(JobQDepth),
                      "job queue count exceeds its depth")

endmodule

@@ rtl/core/b64se_back.sv @@
// Back end: walks each job one character per cycle, while out_o is free or taken, into the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module b64se_back
  import b64se_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_empty_i,
  output logic      job_pop_o,
  output out_word_t out_o,
  output logic      empty_o,
  input  logic      pop_i
);

  logic [JobIdxW-1:0] idx_q, idx_d;
  logic               valid_q, valid_d;
  out_word_t          word_q, word_d;
  logic               load, at_end;

  assign at_end    = (idx_q == job_i.last_idx);
  assign load      = !job_empty_i && (!valid_q || pop_i);
  assign job_pop_o = load && at_end;

  always_comb begin
    word_d.out_char = job_i.chars[idx_q];
    word_d.out_last = job_i.fin && at_end;
    idx_d           = idx_q;
    valid_d         = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = at_end ? '0 : idx_q + 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
    end
  end

  assign out_o   = word_q;
  assign empty_o = !valid_q;

  `B64SE_ASSERT(a_idx_in_job, clk_i, rst_ni,
                !job_empty_i |-> (idx_q <= job_i.last_idx),
                "character index ran past the end of the current job")

endmodule

@@ tb/tb_base64_stream_encoder.sv @@
// Self-checking testbench for the base64 stream encoder, with directed and random messages.
`timescale 1ns / 1ps

import b64se_pkg::*;

// Tracks the characters the encoder owes. It encodes every accepted byte on its own
// and compares each character word that leaves the block with the oldest one owed.
class b64_char_board;
  out_word_t  expected_chars[$];
  logic [3:0] carry_bits;
  phase_e     group_pos;
  int         errors;
  int         bytes_seen;
  int         chars_seen;
  int         messages;
  int         ends_at[3];

  function new();
    carry_bits = '0;
    group_pos  = PhaseFirst;
    errors     = 0;
    bytes_seen = 0;
    chars_seen = 0;
    messages   = 0;
    foreach (ends_at[i]) ends_at[i] = 0;
  endfunction

  // Standard alphabet lookup for one 6-bit group.
  function logic [6:0] sextet_ascii(logic [5:0] v);
    string abc;
    byte   c;
    abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    c = abc[v];
    return c[6:0];
  endfunction

  function void owe_char(logic [6:0] c, logic fin);
    out_word_t w;
    w.out_char = c;
    w.out_last = fin;
    expected_chars.push_back(w);
  endfunction

  // Works out the characters that one accepted byte releases.
  function void encode_byte(in_word_t w);
    logic [7:0] b;
    logic       fin;
    b   = w.data_byte;
    fin = w.last_byte;
    bytes_seen++;
    if (fin) begin
      messages++;
      ends_at[int'(group_pos)]++;
    end
    case (group_pos)
      PhaseSecond: begin
        owe_char(sextet_ascii({carry_bits[1:0], b[7:4]}), 1'b0);
        if (fin) begin
          owe_char(sextet_ascii({b[3:0], 2'b00}), 1'b0);
          owe_char(CharPad, 1'b1);
          carry_bits = '0;
          group_pos  = PhaseFirst;
        end else begin
          carry_bits = b[3:0];
          group_pos  = PhaseThird;
        end
      end
      PhaseThird: begin
        owe_char(sextet_ascii({carry_bits, b[7:6]}), 1'b0);
        owe_char(sextet_ascii(b[5:0]), fin);
        carry_bits = '0;
        group_pos  = PhaseFirst;
      end
      default: begin
        owe_char(sextet_ascii(b[7:2]), 1'b0);
        if (fin) begin
          owe_char(sextet_ascii({b[1:0], 4'b0000}), 1'b0);
          owe_char(CharPad, 1'b0);
          owe_char(CharPad, 1'b1);
          carry_bits = '0;
          group_pos  = PhaseFirst;
        end else begin
          carry_bits = {2'b00, b[1:0]};
          group_pos  = PhaseSecond;
        end
      end
    endcase
  endfunction

  task report(string msg);
    if (errors < 40) $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task check_char(out_word_t got);
    out_word_t want;
    chars_seen++;
    if (expected_chars.size() == 0) begin
      report($sformatf("character 0x%02h arrived with nothing owed", got.out_char));
      return;
    end
    want = expected_chars.pop_front();
    if (got.out_char !== want.out_char)
      report($sformatf("character %0d: out_char 0x%02h, wanted 0x%02h",
                       chars_seen, got.out_char, want.out_char));
    if (got.out_last !== want.out_last)
      report($sformatf("character %0d: out_last %b, wanted %b",
                       chars_seen, got.out_last, want.out_last));
  endtask
endclass

module tb_base64_stream_encoder;

  // The clock starts low so that the first rising edge falls inside reset.
  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  in_word_t  in_word = '0;
  logic      push    = 1'b0;
  logic      full;
  out_word_t out_word;
  logic      empty;
  logic      pop     = 1'b0;

  b64_char_board board;

  // While these are set, the sender and the receiver never pause.
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_hold = 0;
  int rand_bytes;
  bit drained_once = 1'b0;

  // Directed messages: all-zero and all-one bytes, a group that gives only '+'
  // and one that gives only '/', and messages that end at each of the three
  // positions in a group, so that both the "==" and the "=" padding and the
  // unpadded ending all occur. Back-to-back messages check that the encoder
  // starts afresh after every final byte.
  localparam in_word_t DirectedWords [20] = '{
    {8'h00, 1'b1},
    {8'hFF, 1'b1},
    {8'hFF, 1'b0}, {8'h00, 1'b1},
    {8'hFB, 1'b0}, {8'hEF, 1'b0}, {8'hBE, 1'b1},
    {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'h00, 1'b1},
    {8'h4D, 1'b0}, {8'h61, 1'b0}, {8'h6E, 1'b0}, {8'h00, 1'b0}, {8'hFF, 1'b1},
    {8'h55, 1'b0}, {8'hAA, 1'b0}, {8'h80, 1'b0}, {8'h01, 1'b1}
  };

  base64_stream_encoder u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_word),
    .push_i  (push),
    .full_o  (full),
    .out_o   (out_word),
    .empty_o (empty),
    .pop_i   (pop)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Every input is driven with nonblocking assignments at the rising edge, so
  // sampling right after the edge sees the values the encoder saw at that edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) board.encode_byte(in_word);
      if (pop && !empty) board.check_char(out_word);
    end
  end

  // Receiver: now and then it stalls, and a stall can last long enough for
  // the job queue to fill and full to rise.
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      pop     <= 1'b0;
    end else if (rst_n && !rx_calm && $urandom_range(99) < 4) begin
      rx_hold <= $urandom_range(3);
      pop     <= 1'b0;
    end else begin
      pop <= rst_n;
    end
  end

  // Offers one word and returns at the edge where it was taken. The caller is
  // always at a rising edge, so push stays high from one word to the next
  // without a second assignment in the same step.
  task send_byte(in_word_t w);
    if (!tx_calm && $urandom_range(99) < 4) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_word <= w;
    push    <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Waits, with push low, until every owed character has left the block. The
  // count is read at the falling edge where nothing is changing.
  task drain_chars();
    push <= 1'b0;
    @(posedge clk);
    while (board.expected_chars.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int         len;
    int         i;
    in_word_t   w;
    board = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 20; i++) send_byte(DirectedWords[i]);

    // Random messages, mostly short, now and then up to thirty bytes. Every
    // message is well formed since any byte run with a flag on its final byte
    // is a legal stream. Zero and all-one bytes are mixed in on purpose.
    rand_bytes = 0;
    while (rand_bytes < 300) begin
      tx_calm = (rand_bytes >= 60 && rand_bytes < 140);
      rx_calm <= tx_calm;
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      for (i = 0; i < len; i++) begin
        case ($urandom_range(7))
          0:       w.data_byte = 8'h00;
          1:       w.data_byte = 8'hFF;
          default: w.data_byte = $urandom_range(255);
        endcase
        w.last_byte = (i == len - 1);
        send_byte(w);
        rand_bytes++;
      end
      // Once in the run the sender holds off until the encoder has fully drained.
      if (!drained_once && rand_bytes >= 180) begin
        drain_chars();
        drained_once = 1'b1;
      end
    end

    drain_chars();
    repeat (10) @(posedge clk);

    $display("Covered %0d bytes in %0d messages, ending at group positions 1/2/3: %0d/%0d/%0d.",
             board.bytes_seen, board.messages,
             board.ends_at[0], board.ends_at[1], board.ends_at[2]);
    $display("Checked %0d characters with sender gaps, receiver stalls and one full drain.",
             board.chars_seen);
    if (board.errors == 0) begin
      $display("tb_base64_stream_encoder: done, clean");
    end else begin
      $display("tb_base64_stream_encoder: done, errors");
    end
    $finish;
  end

  // A clean run needs well under a tenth of this time.
  initial begin
    #2_000_000;
    $display("Timeout: the encoder stopped taking or giving words.");
    $display("tb_base64_stream_encoder: done, errors");
    $finish;
  end

endmodule
